/* rtl/psn_pkg.sv */
// Shared types and constants for the nearest palette color search block.
package psn_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_FETCH,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Request kinds carried on tuser
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_DIRECT = 2'd1,
        CMD_SHADE  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Per-cycle control seen by every palette cell
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    localparam int COLOR_W = 24;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;

    localparam logic [7:0] SHADE_FADE_START = 8'd224;
    localparam logic [7:0] FULL_LEVEL       = 8'd255;
    localparam int         FADE_SHIFT       = 5;

endpackage

/* rtl/psn_cell.sv */
// One palette cell: holds an RGB entry and passes it to its neighbor while the ring turns.
module psn_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psn_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_sel,
    input  logic [psn_pkg::COLOR_W-1:0]  i_wdata,
    input  logic [psn_pkg::COLOR_W-1:0]  i_next,
    output logic [psn_pkg::COLOR_W-1:0]  o_entry
);
    import psn_pkg::*;

    logic [COLOR_W-1:0] r_entry;
    logic [COLOR_W-1:0] n_entry;

    // rotate, write, or hold
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_entry = i_next;
        end else if (i_ctl.load && i_sel) begin
            n_entry = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

/* rtl/psn_dist.sv */
// Distance stage: squared per-channel differences between an entry and the query color.
module psn_dist (
    input  logic                         i_clk,
    input  logic [psn_pkg::COLOR_W-1:0]  i_entry,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    output logic [psn_pkg::SQ_W-1:0]     o_sq_red,
    output logic [psn_pkg::SQ_W-1:0]     o_sq_green,
    output logic [psn_pkg::SQ_W-1:0]     o_sq_blue
);
    import psn_pkg::*;

    logic [7:0]      w_dr, w_dg, w_db;
    logic [SQ_W-1:0] r_sq_red, r_sq_green, r_sq_blue;

    // absolute differences
    always_comb begin
        w_dr = (i_red   > i_entry[23:16]) ? i_red   - i_entry[23:16] : i_entry[23:16] - i_red;
        w_dg = (i_green > i_entry[15:8])  ? i_green - i_entry[15:8]  : i_entry[15:8]  - i_green;
        w_db = (i_blue  > i_entry[7:0])   ? i_blue  - i_entry[7:0]   : i_entry[7:0]   - i_blue;
    end

    // 8x8 squares, registered
    always_ff @(posedge i_clk) begin
        r_sq_red   <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_green <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_blue  <= SQ_W'(w_db) * SQ_W'(w_db);
    end

    assign o_sq_red   = r_sq_red;
    assign o_sq_green = r_sq_green;
    assign o_sq_blue  = r_sq_blue;

endmodule

/* rtl/palette_shade_nearest_colour.sv */
// Top level: palette ring of cells, distance stage, running minimum and request control.
// Flow: after acceptance the entry index is reduced by PALETTE_ENTRIES in ST_WRAP until it is in
//   range; a write then loads the selected cell, a direct query scans the ring once, and a shade
//   query first turns the ring once in ST_FETCH to fetch (and for top shades fade) its base entry.
// Requests: one at a time, the next accepted only back in ST_IDLE; the ring rotates one cell per
//   cycle while it turns, and ST_DONE holds while the result waits on o_m_tready.
module palette_shade_nearest_colour #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // entry_index[7:0], shade[15:8], red[23:16], green[31:24], blue[39:32]
    input  logic [1:0]  i_s_tuser,   // command[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // closest_index[7:0]
);
    import psn_pkg::*;

    // Reset (synchronous, active low) clears all palette entries to zero and idles control.
    localparam int IW = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int WW = (IW > 8) ? IW : 8;
    localparam logic [IW-1:0] LAST_IDX = IW'(PALETTE_ENTRIES - 1);

    // fade c toward white: c + (255 - c) * k / 32
    function automatic logic [7:0] fade(input logic [7:0] c, input logic [4:0] k);
        logic [12:0] prod;
        begin
            prod = 13'(FULL_LEVEL - c) * 13'(k);
            fade = c + 8'(prod >> FADE_SHIFT);
        end
    endfunction

    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [WW-1:0]       r_idx;
    logic [7:0]          r_shade;
    logic [7:0]          r_red, r_green, r_blue;
    logic [IW-1:0]       r_cnt;
    logic                r_s1_valid;
    logic [IW-1:0]       r_s1_idx;
    logic                r_have;
    logic [DIST_W-1:0]   r_best;
    logic [IW-1:0]       r_best_idx;
    logic                r_out_valid;
    logic [7:0]          r_out_data;

    t_cell_ctl           w_ctl;
    logic [COLOR_W-1:0]  w_entry [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] w_sel;
    logic [SQ_W-1:0]     w_sq_r, w_sq_g, w_sq_b;
    logic [DIST_W-1:0]   w_dist;
    logic                w_accept;
    logic                w_wrap_sub;
    logic                w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_wrap_sub = (32'(r_idx) >= 32'(PALETTE_ENTRIES));
    assign w_out_free = !r_out_valid || i_m_tready;

    // next state and cell control
    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        o_s_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (!w_wrap_sub) begin
                    case (r_cmd)
                        CMD_WRITE: begin
                            w_ctl.load = 1'b1;
                            n_state    = ST_IDLE;
                        end
                        CMD_DIRECT: n_state = ST_SCAN;
                        CMD_SHADE:  n_state = ST_FETCH;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH: begin
                w_ctl.shift = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_ctl.shift = 1'b1;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture, index wrap, base entry fetch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_s_tuser);
            r_idx   <= WW'(i_s_tdata[7:0]);
            r_shade <= i_s_tdata[15:8];
            r_red   <= i_s_tdata[23:16];
            r_green <= i_s_tdata[31:24];
            r_blue  <= i_s_tdata[39:32];
        end else if (r_state == ST_WRAP && w_wrap_sub) begin
            r_idx <= r_idx - WW'(PALETTE_ENTRIES);
        end else if (r_state == ST_FETCH && r_cnt == r_idx[IW-1:0]) begin
            if (r_shade >= SHADE_FADE_START) begin
                r_red   <= fade(w_entry[0][23:16], 5'(r_shade - SHADE_FADE_START));
                r_green <= fade(w_entry[0][15:8],  5'(r_shade - SHADE_FADE_START));
                r_blue  <= fade(w_entry[0][7:0],   5'(r_shade - SHADE_FADE_START));
            end else begin
                r_red   <= w_entry[0][23:16];
                r_green <= w_entry[0][15:8];
                r_blue  <= w_entry[0][7:0];
            end
        end
    end

    // ring position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == ST_FETCH || r_state == ST_SCAN) begin
            r_cnt <= (r_cnt == LAST_IDX) ? '0 : r_cnt + 1'b1;
        end
    end

    // palette ring
    genvar k;
    generate
        for (k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
            assign w_sel[k] = (r_idx[IW-1:0] == IW'(k));
            psn_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_sel   (w_sel[k]),
                .i_wdata ({r_red, r_green, r_blue}),
                .i_next  (w_entry[(k + 1) % PALETTE_ENTRIES]),
                .o_entry (w_entry[k])
            );
        end
    endgenerate

    psn_dist u_dist (
        .i_clk      (i_clk),
        .i_entry    (w_entry[0]),
        .i_red      (r_red),
        .i_green    (r_green),
        .i_blue     (r_blue),
        .o_sq_red   (w_sq_r),
        .o_sq_green (w_sq_g),
        .o_sq_blue  (w_sq_b)
    );

    // track which entry the squares belong to
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= (r_state == ST_SCAN);
        end
        r_s1_idx <= r_cnt;
    end

    assign w_dist = DIST_W'(w_sq_r) + DIST_W'(w_sq_g) + DIST_W'(w_sq_b);

    // running minimum, first strict minimum wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (r_state == ST_WRAP) begin
            r_have <= 1'b0;
        end else if (r_s1_valid && (!r_have || w_dist < r_best)) begin
            r_have <= 1'b1;
        end
        if (r_s1_valid && (!r_have || w_dist < r_best)) begin
            r_best     <= w_dist;
            r_best_idx <= r_s1_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= 8'(r_best_idx);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* tb/sv/tb_palette_shade_nearest_colour.sv */
// Self-checking testbench for the nearest palette color search block, with its own palette model.
module tb_palette_shade_nearest_colour;
    import psn_pkg::*;

    localparam int          PALETTE_ENTRIES = 256;
    localparam int unsigned FADE_STEPS      = 32;
    localparam int unsigned DIST_START      = 1 << 30;
    localparam int          ITEMS_PER_PHASE = 150;
    localparam int          HOLD_CYCLES     = 3000;
    // Longest silent stretch: a shade request takes two ring turns plus overhead
    localparam int          DRAIN_CYCLES    = 3 * PALETTE_ENTRIES;
    localparam int          CYCLE_LIMIT     = 2_000_000;

    // Palette mirror, nearest-entry predictor and queue of expected indexes
    class palette_scoreboard;
        logic [23:0] palette_copy [PALETTE_ENTRIES];
        logic [7:0]  expected_index_q [$];
        int unsigned mismatches;

        function new();
            foreach (palette_copy[i]) palette_copy[i] = '0;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        function int unsigned comp_sq(logic [7:0] a, logic [7:0] b);
            int diff;
            diff = int'(a) - int'(b);
            return diff * diff;
        endfunction

        // Fade toward white for the top shade levels, truncating
        function logic [7:0] fade_level(logic [7:0] c, logic [7:0] shade);
            int unsigned k;
            if (shade < SHADE_FADE_START) return c;
            k = int'(shade) - int'(SHADE_FADE_START);
            return 8'(int'(c) + ((int'(FULL_LEVEL) - int'(c)) * k) / FADE_STEPS);
        endfunction

        // Scan from entry 0; first strict minimum wins, exact hit stops early
        function logic [7:0] nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned best_dist;
            int unsigned entry_dist;
            int          best_idx;
            best_dist = DIST_START;
            best_idx  = 0;
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                entry_dist = comp_sq(r, palette_copy[i][23:16])
                           + comp_sq(g, palette_copy[i][15:8])
                           + comp_sq(b, palette_copy[i][7:0]);
                if (entry_dist == 0) return 8'(i);
                if (entry_dist < best_dist) begin
                    best_dist = entry_dist;
                    best_idx  = i;
                end
            end
            return 8'(best_idx);
        endfunction

        function void note_request(t_cmd cmd, logic [7:0] idx, logic [7:0] shade,
                                   logic [7:0] red, logic [7:0] green, logic [7:0] blue);
            logic [23:0] base;
            base = palette_copy[idx % PALETTE_ENTRIES];
            case (cmd)
                CMD_WRITE: begin
                    palette_copy[idx % PALETTE_ENTRIES] = {red, green, blue};
                end
                CMD_DIRECT: begin
                    expected_index_q.push_back(nearest_entry(red, green, blue));
                end
                CMD_SHADE: begin
                    expected_index_q.push_back(nearest_entry(fade_level(base[23:16], shade),
                                                             fade_level(base[15:8], shade),
                                                             fade_level(base[7:0], shade)));
                end
                default: ;
            endcase
        endfunction

        task check_result(logic [7:0] closest_index);
            logic [7:0] want;
            if (expected_index_q.size() == 0) begin
                report($sformatf("result %0d with no request outstanding", closest_index));
            end else begin
                want = expected_index_q.pop_front();
                if (closest_index !== want)
                    report($sformatf("closest_index got %0d, want %0d", closest_index, want));
            end
        endtask

        task check_leftovers();
            if (expected_index_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_index_q.size()));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // entry_index[7:0], shade[15:8], red[23:16], green[31:24], blue[39:32]
    logic [1:0]  i_s_tuser;   // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // closest_index[7:0]

    palette_scoreboard sb = new();
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_active    = 1'b0;
    int unsigned cycle_count    = 0;
    event        hold_off_ev;

    palette_shade_nearest_colour #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Long receiver hold-off, counted here
    initial begin
        forever begin
            @(hold_off_ev);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    // Result side: check accepted results, then pick next ready
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (hold_active) begin
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request; valid stays high afterwards unless the next call idles
    task automatic send_request(t_cmd cmd, logic [7:0] idx, logic [7:0] shade,
                                logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {blue, green, red, shade, idx};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(cmd, idx, shade, red, green, blue);
    endtask

    function automatic logic [7:0] extreme_level();
        return $urandom_range(1) ? 8'hFF : 8'h00;
    endfunction

    // Random color: fully random, a copy of a stored entry, or corner levels
    function automatic logic [23:0] pick_colour(int copy_pct, int corner_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < copy_pct) return sb.palette_copy[$urandom_range(PALETTE_ENTRIES - 1)];
        if (roll < copy_pct + corner_pct) return {extreme_level(), extreme_level(), extreme_level()};
        return 24'($urandom);
    endfunction

    task automatic send_random_item(bit queries_only);
        int          roll;
        logic [23:0] colour;
        logic [7:0]  shade;
        roll = queries_only ? $urandom_range(35, 94) : $urandom_range(99);
        shade = $urandom_range(1) ? 8'($urandom_range(SHADE_FADE_START, FULL_LEVEL))
                                  : 8'($urandom);
        if (roll < 35) begin
            colour = pick_colour(15, 15);
            send_request(CMD_WRITE, 8'($urandom), 8'($urandom),
                         colour[23:16], colour[15:8], colour[7:0]);
        end else if (roll < 60) begin
            colour = pick_colour(40, 20);
            send_request(CMD_DIRECT, 8'($urandom), 8'($urandom),
                         colour[23:16], colour[15:8], colour[7:0]);
        end else if (roll < 95) begin
            colour = 24'($urandom);
            send_request(CMD_SHADE, 8'($urandom), shade,
                         colour[23:16], colour[15:8], colour[7:0]);
        end else begin
            colour = 24'($urandom);
            send_request(CMD_NONE, 8'($urandom), 8'($urandom),
                         colour[23:16], colour[15:8], colour[7:0]);
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_NONE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty palette, ties, exact hits, shade bounds, ignored fields
        send_request(CMD_DIRECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_DIRECT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_SHADE,  8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_request(CMD_WRITE,  8'hFF, 8'hA5, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_WRITE,  8'h80, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_request(CMD_WRITE,  8'h81, 8'hFF, 8'hFF, 8'h00, 8'h00);
        send_request(CMD_WRITE,  8'h00, 8'h00, 8'h0A, 8'h14, 8'h1E);
        send_request(CMD_DIRECT, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_DIRECT, 8'hFF, 8'hFF, 8'hFA, 8'h05, 8'h05);
        send_request(CMD_DIRECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_SHADE,  8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_SHADE,  8'h80, 8'd223, 8'h00, 8'h00, 8'h00);
        send_request(CMD_SHADE,  8'h80, SHADE_FADE_START, 8'h00, 8'h00, 8'h00);
        send_request(CMD_SHADE,  8'h80, FULL_LEVEL, 8'h00, 8'h00, 8'h00);
        send_request(CMD_SHADE,  8'h00, 8'd240, 8'h12, 8'h34, 8'h56);
        send_request(CMD_NONE,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_NONE,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(CMD_WRITE,  8'h01, 8'h00, 8'h7F, 8'h80, 8'h01);
        send_request(CMD_DIRECT, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h01);
        send_request(CMD_SHADE,  8'h01, 8'd225, 8'hFF, 8'hFF, 8'hFF);
        send_request(CMD_SHADE,  8'h02, FULL_LEVEL, 8'h00, 8'h00, 8'h00);

        // Receiver holds off while queries keep coming, so the input stalls
        -> hold_off_ev;
        repeat (12) send_random_item(1'b1);

        // Random phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item(1'b0);
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for a late stray result
        recv_stall_pct = 0;
        while (sb.expected_index_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.check_leftovers();
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* palette_shade_nearest_colour.f */
rtl/psn_pkg.sv
rtl/psn_cell.sv
rtl/psn_dist.sv
rtl/palette_shade_nearest_colour.sv
tb/sv/tb_palette_shade_nearest_colour.sv
